>>> sv/als_pkg.sv
// Shared types and codes for the adjacency list store.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package als_pkg;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_LIST  = 2'd2;
   localparam logic [1:0] FUNC_BAD   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [4:0] NODE_COUNT_RESET = 5'd16;
   localparam int unsigned ID_NODES = 16;

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_ERR   = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_FULL  = 4'd4;
   localparam logic [3:0] OP_MISS  = 4'd5;
   localparam logic [3:0] OP_START = 4'd6;
   localparam logic [3:0] OP_NEXT  = 4'd7;
   localparam logic [3:0] OP_HIT   = 4'd8;
   localparam logic [3:0] OP_ITEM  = 4'd9;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] orig;
      logic [3:0] dest;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [3:0] neighbor;
      logic [3:0] position;
      logic [4:0] degree;
      logic [8:0] compact_offset;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       err;
      logic       full;
      logic       empty;
      logic       hit;
      logic       walk_end;
   } sts_type;

endpackage

`default_nettype wire

>>> sv/adjacency_list_store.sv
// Adjacency list store: per-node neighbour rows with degree and compact offsets.
// Sequence: accept, setup, then for query and list a row walk, and the result register.
// Add edge and rejects end after setup; query and list on a non-empty row walk it, paced by
// the single RAM port reading one neighbour per cycle. The next start is taken while the
// final result shows. The receiver cannot stall results.
// Synchronous reset clears degree counters, sets node_count to 16; rows are kept.
`default_nettype none

module adjacency_list_store
   import als_pkg::*;
#(
   parameter int unsigned NODES      = 16,
   parameter int unsigned MAX_DEGREE = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [4:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = !busy;

   als_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   als_datapath #(
      .NODES      (NODES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("final result while still busy");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("partial result after the item ended");

   a_range_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_RANGE |->
         rsp_data.degree == '0 && rsp_data.compact_offset == '0 && rsp_data.last)
      else $error("range error result carries data");

endmodule

`default_nettype wire

>>> sv/als_ram.sv
// Generic single-port RAM with registered read data.
// Holds the neighbour rows; no package dependency.
`default_nettype none

module als_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/als_ctrl.sv
// Sequencer of the adjacency list store: accept, setup and row walk.
// Uses als_pkg for command and status structs.
`default_nettype none

module als_ctrl
   import als_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output logic         busy,
   output cmd_type      cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            state_in = S_IDLE;
            if (sts.err) begin
               cmd.op = OP_ERR;
            end else if (sts.func == FUNC_ADD) begin
               cmd.op = sts.full ? OP_FULL : OP_ADD;
            end else if (sts.empty) begin
               cmd.op = OP_MISS;
            end else begin
               cmd.op   = OP_START;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.func == FUNC_QUERY) begin
               if (sts.hit) begin
                  cmd.op   = OP_HIT;
                  state_in = S_IDLE;
               end else if (sts.walk_end) begin
                  cmd.op   = OP_MISS;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_NEXT;
               end
            end else begin
               cmd.op = OP_ITEM;
               if (sts.walk_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_SETUP)
      else $error("accepted item did not enter setup");

   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SETUP && sts.err |=> state_ff == S_IDLE)
      else $error("rejected item did not end at once");

   a_empty_no_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SETUP && sts.empty |=> state_ff != S_WALK)
      else $error("walk started on an empty row");

endmodule

`default_nettype wire

>>> sv/als_datapath.sv
// Datapath: request latch, degree and offset counters, neighbour RAM, result register.
// Uses als_pkg and instantiates als_ram.
`default_nettype none

module als_datapath
   import als_pkg::*;
#(
   parameter int unsigned NODES      = 16,
   parameter int unsigned MAX_DEGREE = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire logic       csr_write,
   input  wire logic [4:0] csr_data,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   localparam int unsigned USED_NODES = (NODES < ID_NODES) ? NODES : ID_NODES;
   localparam int unsigned NODE_W     = $clog2(USED_NODES);
   localparam int unsigned IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int unsigned DEG_W      = $clog2(MAX_DEGREE + 1);
   localparam int unsigned CNT_W      = IDX_W + 1;
   localparam int unsigned RAM_DEPTH  = USED_NODES << IDX_W;
   localparam logic [4:0]  USED_LIM   = 5'(USED_NODES);

   req_type              req_ff;
   logic [4:0]           node_count_ff;
   logic [DEG_W-1:0]     deg_ff    [USED_NODES];
   logic [8:0]           prefix_ff [USED_NODES];
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   logic [4:0]           limit;
   logic [NODE_W-1:0]    orig_ix;
   logic [DEG_W-1:0]     deg_sel;
   logic [8:0]           off_sel;
   logic [IDX_W-1:0]     idx_next;
   logic [NODE_W+IDX_W-1:0] ram_addr;
   logic                 ram_we;
   logic [3:0]           ram_rdata;

   assign limit    = (node_count_ff < USED_LIM) ? node_count_ff : USED_LIM;
   assign orig_ix  = req_ff.orig[NODE_W-1:0];
   assign deg_sel  = deg_ff[orig_ix];
   assign off_sel  = prefix_ff[orig_ix];
   assign idx_next = idx_ff + 1'b1;

   assign sts.func     = req_ff.func;
   assign sts.err      = (req_ff.func == FUNC_BAD) || ({1'b0, req_ff.orig} >= limit) ||
                         ((req_ff.func != FUNC_LIST) && ({1'b0, req_ff.dest} >= limit));
   assign sts.full     = (deg_sel == DEG_W'(MAX_DEGREE));
   assign sts.empty    = (deg_sel == '0);
   assign sts.hit      = (ram_rdata == req_ff.dest);
   assign sts.walk_end = (({1'b0, idx_ff} + CNT_W'(1)) == CNT_W'(deg_sel));

   assign ram_we = (cmd.op == OP_ADD);

   always_comb begin
      case (cmd.op)
         OP_ADD:   ram_addr = {orig_ix, deg_sel[IDX_W-1:0]};
         OP_START: ram_addr = {orig_ix, {IDX_W{1'b0}}};
         default:  ram_addr = {orig_ix, idx_next};
      endcase
   end

   als_ram #(
      .WIDTH (4),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_ff.dest),
      .rdata (ram_rdata)
   );

   always_comb begin
      idx_in                = idx_ff;
      rsp_valid_in          = 1'b1;
      rsp_in                = '0;
      rsp_in.degree         = 5'(deg_sel);
      rsp_in.compact_offset = off_sel;
      rsp_in.last           = 1'b1;
      case (cmd.op)
         OP_ERR: begin
            rsp_in                = '0;
            rsp_in.status         = STATUS_RANGE;
            rsp_in.last           = 1'b1;
         end
         OP_ADD: begin
            rsp_in.position = 4'(deg_sel);
            rsp_in.degree   = 5'(deg_sel + 1'b1);
         end
         OP_FULL: begin
            rsp_in.status = STATUS_FULL;
         end
         OP_MISS: begin
            rsp_in.status = STATUS_OK;
         end
         OP_HIT: begin
            rsp_in.found    = 1'b1;
            rsp_in.position = 4'(idx_ff);
         end
         OP_ITEM: begin
            rsp_in.neighbor = ram_rdata;
            rsp_in.position = 4'(idx_ff);
            rsp_in.last     = sts.walk_end;
            idx_in          = idx_next;
         end
         OP_START: begin
            rsp_valid_in = 1'b0;
            idx_in       = '0;
         end
         OP_NEXT: begin
            rsp_valid_in = 1'b0;
            idx_in       = idx_next;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < USED_NODES; j++) begin
            deg_ff[j]    <= '0;
            prefix_ff[j] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            node_count_ff <= csr_data;
         end
         if (cmd.op == OP_ADD) begin
            deg_ff[orig_ix] <= deg_sel + 1'b1;
            for (int j = 0; j < USED_NODES; j++) begin
               if (NODE_W'(j) > orig_ix) begin
                  prefix_ff[j] <= prefix_ff[j] + 9'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_data;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for adjacency_list_store: a directed table, then random
// command streams under several node_count settings, checked against a local model.
// Depends on als_pkg and the adjacency_list_store RTL.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import als_pkg::*;

   localparam int unsigned ROW_SLOTS   = 16;
   localparam int unsigned STALL_LIMIT = 1000;

   typedef enum logic [1:0] {ROW_SEND, ROW_CHECKED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      rsp_type      reply;
      logic [4:0]   csr_value;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data = '0;

   logic [4:0]   node_count_cfg = NODE_COUNT_RESET;
   logic [4:0]   degree_of [ID_NODES];
   logic [3:0]   row_store [ID_NODES][ROW_SLOTS];
   rsp_type      awaited [$];
   plan_row_type plan [$];
   int           failures = 0;
   int           idle_cycles = 0;

   adjacency_list_store DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type rsp_of(input logic [1:0] status, input logic found,
                                      input logic [3:0] nb, input logic [3:0] pos,
                                      input logic [4:0] deg, input logic [8:0] off,
                                      input logic last);
      rsp_type r;
      r.status         = status;
      r.found          = found;
      r.neighbor       = nb;
      r.position       = pos;
      r.degree         = deg;
      r.compact_offset = off;
      r.last           = last;
      return r;
   endfunction

   function automatic req_type req_of(input logic [1:0] func, input logic [3:0] orig,
                                      input logic [3:0] dest);
      req_type it;
      it.func = func;
      it.orig = orig;
      it.dest = dest;
      return it;
   endfunction

   function automatic int node_limit();
      return (node_count_cfg < ID_NODES) ? int'(node_count_cfg) : int'(ID_NODES);
   endfunction

   // Apply one command to the local graph and return the results it causes.
   function automatic void graph_step(input req_type it, output rsp_type outs[$]);
      int         lim;
      logic [4:0] deg;
      logic [8:0] off;
      logic       hit;
      logic [3:0] pos;
      outs = {};
      lim = node_limit();
      if (it.func == FUNC_BAD || it.orig >= lim ||
          (it.func != FUNC_LIST && it.dest >= lim)) begin
         outs.push_back(rsp_of(STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1));
         return;
      end
      off = '0;
      for (int i = 0; i < it.orig; i++) off = off + degree_of[i];
      deg = degree_of[it.orig];
      case (it.func)
         FUNC_ADD: begin
            if (deg >= ROW_SLOTS) begin
               outs.push_back(rsp_of(STATUS_FULL, 1'b0, '0, '0, deg, off, 1'b1));
            end else begin
               row_store[it.orig][deg[3:0]] = it.dest;
               degree_of[it.orig] = deg + 5'd1;
               outs.push_back(rsp_of(STATUS_OK, 1'b0, '0, deg[3:0], deg + 5'd1, off, 1'b1));
            end
         end
         FUNC_QUERY: begin
            hit = 1'b0;
            pos = '0;
            for (int i = 0; i < deg; i++) begin
               if (!hit && row_store[it.orig][i] == it.dest) begin
                  hit = 1'b1;
                  pos = 4'(i);
               end
            end
            outs.push_back(rsp_of(STATUS_OK, hit, '0, pos, deg, off, 1'b1));
         end
         default: begin
            if (deg == 0) begin
               outs.push_back(rsp_of(STATUS_OK, 1'b0, '0, '0, '0, off, 1'b1));
            end else begin
               for (int i = 0; i < deg; i++)
                  outs.push_back(rsp_of(STATUS_OK, 1'b0, row_store[it.orig][i], 4'(i),
                                        deg, off, (i + 1 == deg)));
            end
         end
      endcase
   endfunction

   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      int          lim;
      lim  = node_limit();
      pick = $urandom_range(99);
      if (pick < 45)      it.func = FUNC_ADD;
      else if (pick < 70) it.func = FUNC_QUERY;
      else if (pick < 90) it.func = FUNC_LIST;
      else if (pick < 94) it.func = FUNC_BAD;
      else                it.func = 2'($urandom_range(3));
      it.orig = 4'($urandom_range(lim - 1));
      it.dest = 4'($urandom_range(lim - 1));
      if ($urandom_range(9) == 0) it.orig = 4'($urandom_range(15));
      if ($urandom_range(9) == 0) it.dest = 4'($urandom_range(15));
      if (it.func == FUNC_QUERY && degree_of[it.orig] != 0 && $urandom_range(1))
         it.dest = row_store[it.orig][$urandom_range(degree_of[it.orig] - 1)];
      return it;
   endfunction

   // Hold start high until the transfer, then queue what it should produce.
   task automatic send_item(input req_type it, input logic typed, input rsp_type reply);
      rsp_type outs [$];
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy !== 1'b0);
      graph_step(it, outs);
      if (typed) awaited.push_back(reply);
      else foreach (outs[i]) awaited.push_back(outs[i]);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [4:0] value);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      node_count_cfg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int quiet_tail);
      for (int n = 0; n < count; n++) begin
         send_item(random_item(), 1'b0, '0);
         if (n < count - quiet_tail && $urandom_range(3) == 0)
            pause_sender($urandom_range(1, 10));
      end
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         $error("unexpected result: %p", got);
         failures++;
         return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         failures++;
      end
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         failures++;
      end
      if (got.neighbor !== want.neighbor) begin
         $error("neighbor: expected %0d, got %0d", want.neighbor, got.neighbor);
         failures++;
      end
      if (got.position !== want.position) begin
         $error("position: expected %0d, got %0d", want.position, got.position);
         failures++;
      end
      if (got.degree !== want.degree) begin
         $error("degree: expected %0d, got %0d", want.degree, got.degree);
         failures++;
      end
      if (got.compact_offset !== want.compact_offset) begin
         $error("compact_offset: expected %0d, got %0d", want.compact_offset,
                got.compact_offset);
         failures++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) check_reply(rsp_data);
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1 || (csr_valid && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("** adjacency_list_store: FAILED **");
      $finish;
   end

   initial begin
      plan_row_type r;
      foreach (degree_of[i]) degree_of[i] = '0;
      foreach (row_store[i, j]) row_store[i][j] = '0;

      r.csr_value = '0;
      r.kind = ROW_CHECKED;
      r.item = req_of(FUNC_LIST, 4'd0, 4'd0);
      r.reply = rsp_of(STATUS_OK, 1'b0, '0, '0, '0, '0, 1'b1);
      plan.push_back(r);
      r.item = req_of(FUNC_QUERY, 4'd0, 4'd5);
      plan.push_back(r);
      r.item = req_of(FUNC_BAD, 4'd15, 4'd15);
      r.reply = rsp_of(STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1);
      plan.push_back(r);
      r.kind = ROW_SEND;
      r.reply = '0;
      for (int d = 0; d < 16; d++) begin
         r.item = req_of(FUNC_ADD, 4'd15, 4'(d));
         plan.push_back(r);
      end
      r.kind = ROW_CHECKED;
      r.item = req_of(FUNC_ADD, 4'd15, 4'd7);
      r.reply = rsp_of(STATUS_FULL, 1'b0, '0, '0, 5'd16, '0, 1'b1);
      plan.push_back(r);
      r.kind = ROW_SEND;
      r.item = req_of(FUNC_QUERY, 4'd15, 4'd15);
      plan.push_back(r);
      r.item = req_of(FUNC_LIST, 4'd15, 4'd0);
      plan.push_back(r);
      r.kind = ROW_CSR;
      r.csr_value = 5'd1;
      plan.push_back(r);
      r.kind = ROW_CHECKED;
      r.item = req_of(FUNC_ADD, 4'd0, 4'd1);
      r.reply = rsp_of(STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1);
      plan.push_back(r);
      r.item = req_of(FUNC_LIST, 4'd1, 4'd0);
      plan.push_back(r);
      r.kind = ROW_SEND;
      r.item = req_of(FUNC_ADD, 4'd0, 4'd0);
      plan.push_back(r);
      r.kind = ROW_CHECKED;
      r.item = req_of(FUNC_QUERY, 4'd0, 4'd0);
      r.reply = rsp_of(STATUS_OK, 1'b1, '0, '0, 5'd1, '0, 1'b1);
      plan.push_back(r);
      r.kind = ROW_CSR;
      r.csr_value = NODE_COUNT_RESET;
      plan.push_back(r);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_node_count(plan[i].csr_value);
         else send_item(plan[i].item, plan[i].kind == ROW_CHECKED, plan[i].reply);
      end

      run_random(80, 0);
      write_node_count(5'($urandom_range(2, 15)));
      run_random(35, 0);
      hold_until_drained();
      run_random(35, 0);
      write_node_count(5'd1);
      run_random(30, 0);
      write_node_count(NODE_COUNT_RESET);
      run_random(64, 40);

      hold_until_drained();
      repeat (ROW_SLOTS + 4) @(posedge clock);
      if (failures == 0)
         $display("** adjacency_list_store: PASSED **");
      else
         $display("** adjacency_list_store: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
sv/als_pkg.sv
sv/als_ram.sv
sv/als_ctrl.sv
sv/als_datapath.sv
sv/adjacency_list_store.sv
test/testbench.sv
